[rtl/pwlcm_pkg.sv]
package pwlcm_pkg;

    localparam int MAX_POINTS_DEF = 6;
    localparam int VALUE_BITS_DEF = 24;

    localparam int SAMPLE_W  = 24;
    localparam int PT_W      = 57;
    localparam int PT_VAL_LSB = 33;
    localparam int CHAN0_W   = 9;
    localparam int CHAN_W    = 8;
    localparam int COUNT_W   = 3;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int N_CH      = 4;

    // register indexes on the configuration port
    localparam int REG_POINT_COUNT = 0;
    localparam int REG_MODE_FLAGS  = 1;
    localparam int REG_POINT_BASE  = 2;

    localparam int MODE_INTERP_BIT = 0;
    localparam int MODE_HSV_BIT    = 1;

    localparam logic [CHAN0_W-1:0] HUE_MAX   = 9'd359;
    localparam logic [CHAN0_W-1:0] RGB_MAX   = 9'd255;
    localparam logic [CHAN0_W-1:0] ALPHA_MAX = 9'd255;

    typedef enum logic [1:0] {
        KIND_BLACK  = 2'd0,
        KIND_COPY   = 2'd1,
        KIND_INTERP = 2'd2
    } kind_t;

endpackage

[rtl/piecewise_linear_colour_map_core.sv]
// channel   | signals                                        | transfer
// ----------+------------------------------------------------+---------------------------
// sample in | start, busy, sample                            | start high, busy low
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data      | cfg_valid and cfg_ready high
// result    | done, chan_first, chan_second, chan_third,     | done high, one cycle
//           | alpha_out                                      |
//
// one sample per cycle; each result passes through selection, operand fetch, multiply, sum,
// then one quotient bit per stage of the 9-stage divider, and the output register
// busy stays low: the pipeline never holds, and the result side takes every done cycle
// reset clears the pipeline valid bits, point_count and points to 0, mode_flags to 1
module piecewise_linear_colour_map_core #(
    parameter int MAX_POINTS = pwlcm_pkg::MAX_POINTS_DEF,
    parameter int VALUE_BITS = pwlcm_pkg::VALUE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [pwlcm_pkg::SAMPLE_W-1:0] sample,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pwlcm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pwlcm_pkg::PT_W-1:0]          cfg_data,
    output logic                                done,
    output logic [pwlcm_pkg::CHAN0_W-1:0]       chan_first,
    output logic [pwlcm_pkg::CHAN_W-1:0]        chan_second,
    output logic [pwlcm_pkg::CHAN_W-1:0]        chan_third,
    output logic [pwlcm_pkg::CHAN_W-1:0]        alpha_out
);
    import pwlcm_pkg::*;

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NUM_W = VALUE_BITS + CHAN0_W;
    localparam int QB    = CHAN0_W;
    localparam int LAT   = QB + 6;

    typedef logic signed [VALUE_BITS-1:0] val_t;
    typedef logic [VALUE_BITS-1:0]        dist_t;
    typedef logic [CHAN0_W-1:0]           chan_t;
    typedef logic [NUM_W-1:0]             num_t;

    // configuration registers
    logic [COUNT_W-1:0] count_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [PT_W-1:0]    pts_reg [MAX_POINTS];

    val_t               pt_val [MAX_POINTS];
    chan_t              pt_ch  [MAX_POINTS][N_CH];
    logic [COUNT_W-1:0] npts;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            mode_reg  <= MODE_W'(1);
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                pts_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            if (int'(cfg_index) == REG_POINT_COUNT)
            begin
                count_reg <= cfg_data[COUNT_W-1:0];
            end
            else if (int'(cfg_index) == REG_MODE_FLAGS)
            begin
                mode_reg <= cfg_data[MODE_W-1:0];
            end
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                if (int'(cfg_index) == REG_POINT_BASE + i)
                begin
                    pts_reg[i] <= cfg_data;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            pt_val[i]   = $signed(pts_reg[i][PT_VAL_LSB +: VALUE_BITS]);
            pt_ch[i][0] = pts_reg[i][32:24];
            pt_ch[i][1] = {1'b0, pts_reg[i][23:16]};
            pt_ch[i][2] = {1'b0, pts_reg[i][15:8]};
            pt_ch[i][3] = {1'b0, pts_reg[i][7:0]};
        end
        npts = (int'(count_reg) > MAX_POINTS) ? COUNT_W'(MAX_POINTS) : count_reg;
    end

    // stage a: sample capture
    logic a_vld_reg;
    val_t a_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        a_v_reg <= sample[VALUE_BITS-1:0];
    end

    // stage b: segment search
    logic             b_vld_reg;
    val_t             b_v_reg;
    kind_t            b_kind_reg, b_kind_next;
    logic [IDX_W-1:0] b_ia_reg, b_ia_next;
    logic [IDX_W-1:0] b_ib_reg, b_ib_next;
    logic             found;

    always_comb
    begin
        found       = 1'b0;
        b_kind_next = KIND_COPY;
        b_ia_next   = IDX_W'(npts - COUNT_W'(1));
        b_ib_next   = '0;
        for (int i = 0; i < MAX_POINTS - 1; i++)
        begin
            if (!found && (i + 1 < int'(npts)) && (a_v_reg >= pt_val[i])
                && (a_v_reg <= pt_val[i+1]))
            begin
                found     = 1'b1;
                b_ia_next = IDX_W'(i);
                b_ib_next = IDX_W'(i + 1);
                b_kind_next = (mode_reg[MODE_INTERP_BIT] && (pt_val[i] != pt_val[i+1]))
                              ? KIND_INTERP : KIND_COPY;
            end
        end
        if (a_v_reg < pt_val[0])
        begin
            b_kind_next = KIND_COPY;
            b_ia_next   = '0;
        end
        if (npts == '0)
        begin
            b_kind_next = KIND_BLACK;
            b_ia_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_v_reg    <= a_v_reg;
        b_kind_reg <= b_kind_next;
        b_ia_reg   <= b_ia_next;
        b_ib_reg   <= b_ib_next;
    end

    // stage c: operands; copy and black run through the divider as c0*1/1
    logic  c_vld_reg;
    dist_t c_d0_reg, c_d0_next;
    dist_t c_d1_reg, c_d1_next;
    dist_t c_w_reg,  c_w_next;
    chan_t c_c0_reg [N_CH];
    chan_t c_c0_next [N_CH];
    chan_t c_c1_reg [N_CH];
    chan_t c_c1_next [N_CH];
    logic signed [VALUE_BITS:0] diff_ev, diff_vs, diff_es;

    always_comb
    begin
        diff_ev = (VALUE_BITS+1)'(pt_val[b_ib_reg]) - (VALUE_BITS+1)'(b_v_reg);
        diff_vs = (VALUE_BITS+1)'(b_v_reg) - (VALUE_BITS+1)'(pt_val[b_ia_reg]);
        diff_es = (VALUE_BITS+1)'(pt_val[b_ib_reg]) - (VALUE_BITS+1)'(pt_val[b_ia_reg]);
        c_d0_next = dist_t'(1);
        c_d1_next = '0;
        c_w_next  = dist_t'(1);
        for (int k = 0; k < N_CH; k++)
        begin
            c_c0_next[k] = pt_ch[b_ia_reg][k];
            c_c1_next[k] = '0;
        end
        case (b_kind_reg)
            KIND_INTERP:
            begin
                c_d0_next = diff_ev[VALUE_BITS-1:0];
                c_d1_next = diff_vs[VALUE_BITS-1:0];
                c_w_next  = diff_es[VALUE_BITS-1:0];
                for (int k = 0; k < N_CH; k++)
                begin
                    c_c1_next[k] = pt_ch[b_ib_reg][k];
                end
            end
            KIND_BLACK:
            begin
                c_c0_next[0] = '0;
                c_c0_next[1] = '0;
                c_c0_next[2] = '0;
                c_c0_next[3] = ALPHA_MAX;
            end
            default:
            begin
                c_d0_next = dist_t'(1);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else
        begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_d0_reg <= c_d0_next;
        c_d1_reg <= c_d1_next;
        c_w_reg  <= c_w_next;
        c_c0_reg <= c_c0_next;
        c_c1_reg <= c_c1_next;
    end

    // stage d: weighted products
    logic  d_vld_reg;
    dist_t d_w_reg;
    num_t  d_p0_reg [N_CH];
    num_t  d_p1_reg [N_CH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
        end
        else
        begin
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_w_reg <= c_w_reg;
        for (int k = 0; k < N_CH; k++)
        begin
            d_p0_reg[k] <= num_t'(c_c0_reg[k]) * num_t'(c_d0_reg);
            d_p1_reg[k] <= num_t'(c_c1_reg[k]) * num_t'(c_d1_reg);
        end
    end

    // divider: stage 0 holds the numerator, stage j resolves quotient bit QB-j
    logic  dv_vld_reg [QB+1];
    dist_t dv_w_reg   [QB+1];
    num_t  dv_rem_reg [QB+1][N_CH];
    chan_t dv_q_reg   [QB+1][N_CH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld_reg[0] <= 1'b0;
        end
        else
        begin
            dv_vld_reg[0] <= d_vld_reg;
        end
    end

    // the sum stays below 2^NUM_W since d0 + d1 == w
    always_ff @(posedge clk)
    begin
        dv_w_reg[0] <= d_w_reg;
        for (int k = 0; k < N_CH; k++)
        begin
            dv_rem_reg[0][k] <= d_p0_reg[k] + d_p1_reg[k];
            dv_q_reg[0][k]   <= '0;
        end
    end

    for (genvar j = 1; j <= QB; j++)
    begin : g_div
        localparam int BIT = QB - j;
        logic [NUM_W:0] trial;
        num_t           rem_next [N_CH];
        chan_t          q_next   [N_CH];

        assign trial = (NUM_W+1)'(dv_w_reg[j-1]) << BIT;

        always_comb
        begin
            for (int k = 0; k < N_CH; k++)
            begin
                rem_next[k] = dv_rem_reg[j-1][k];
                q_next[k]   = dv_q_reg[j-1][k];
                if ((NUM_W+1)'(dv_rem_reg[j-1][k]) >= trial)
                begin
                    rem_next[k]    = NUM_W'((NUM_W+1)'(dv_rem_reg[j-1][k]) - trial);
                    q_next[k][BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[j] <= 1'b0;
            end
            else
            begin
                dv_vld_reg[j] <= dv_vld_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_w_reg[j]   <= dv_w_reg[j-1];
            dv_rem_reg[j] <= rem_next;
            dv_q_reg[j]   <= q_next;
        end
    end

    // output register with channel0 saturation
    logic  done_reg;
    chan_t out_c0_reg;
    logic [CHAN_W-1:0] out_c1_reg, out_c2_reg, out_c3_reg;
    chan_t lim0;

    assign lim0 = mode_reg[MODE_HSV_BIT] ? HUE_MAX : RGB_MAX;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_vld_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        out_c0_reg <= (dv_q_reg[QB][0] > lim0) ? lim0 : dv_q_reg[QB][0];
        out_c1_reg <= dv_q_reg[QB][1][CHAN_W-1:0];
        out_c2_reg <= dv_q_reg[QB][2][CHAN_W-1:0];
        out_c3_reg <= dv_q_reg[QB][3][CHAN_W-1:0];
    end

    assign done        = done_reg;
    assign chan_first  = out_c0_reg;
    assign chan_second = out_c1_reg;
    assign chan_third  = out_c2_reg;
    assign alpha_out   = out_c3_reg;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("accepted sample produced no result at the expected cycle");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        c_vld_reg |-> c_w_reg != '0)
        else $error("divider fed a zero segment width");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld_reg[QB] |-> (NUM_W+1)'(dv_rem_reg[QB][0]) < (NUM_W+1)'(dv_w_reg[QB])
            && (NUM_W+1)'(dv_rem_reg[QB][3]) < (NUM_W+1)'(dv_w_reg[QB]))
        else $error("division remainder not below the divisor");

    a_rgb_limit: assert property (@(posedge clk) disable iff (!rst_n)
        done && !mode_reg[MODE_HSV_BIT] |-> chan_first <= RGB_MAX)
        else $error("red channel above its limit");

    a_hue_limit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> chan_first <= HUE_MAX)
        else $error("channel0 above the hue limit");
`endif

endmodule
